FILE: src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the serial line editor
// Result kinds, command codes, sequencer states and the byte classifier.
// ----------------------------------------------------------------------------
package sle_pkg;

  typedef enum logic [2:0] {
    K_ECHO = 3'd0,
    K_LINE = 3'd1,
    K_BELL = 3'd2,
    K_EOF  = 3'd3,
    K_ERR  = 3'd4,
    K_INTR = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    OP_IGNORE,
    OP_EOF,
    OP_ERR,
    OP_INTR,
    OP_LINE,
    OP_PUT,
    OP_BS,
    OP_KILL,
    OP_WORD,
    OP_REPRINT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STAT,
    S_PUT,
    S_LCR,
    S_LLF,
    S_LBODY,
    S_LEND,
    S_RCR,
    S_RBODY,
    S_WCHK,
    S_RUB1,
    S_RUB2,
    S_RUB3
  } state_t;

  typedef enum logic [1:0] {
    RM_SINGLE,
    RM_KILL,
    RM_WORD
  } rub_mode_t;

  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TOP  = 8'h7E;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_HIGH = 8'hA0;
  localparam logic [7:0] CTL_C   = 8'h03;
  localparam logic [7:0] CTL_R   = 8'h12;
  localparam logic [7:0] CTL_U   = 8'h15;
  localparam logic [7:0] CTL_W   = 8'h17;

  function automatic cmd_t classify(input logic [7:0] b, input logic fe, input logic ovr);
    cmd_t       c;
    logic [7:0] ch;
    ch   = (b == CH_TAB) ? CH_SP : b;
    c.ch = ch;
    c.op = OP_IGNORE;
    if (fe) begin
      c.op = OP_EOF;
    end else if (ovr) begin
      c.op = OP_ERR;
    end else if (b == CH_CR || b == CH_LF) begin
      c.op = OP_LINE;
    end else if ((ch >= CH_SP && ch <= CH_TOP) || ch >= CH_HIGH) begin
      c.op = OP_PUT;
    end else begin
      case (b)
        CTL_C:          c.op = OP_INTR;
        CH_BS, CH_DEL:  c.op = OP_BS;
        CTL_R:          c.op = OP_REPRINT;
        CTL_U:          c.op = OP_KILL;
        CTL_W:          c.op = OP_WORD;
        default:        c.op = OP_IGNORE;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: src/sle_if.sv
// ----------------------------------------------------------------------------
// sle_if: word channels of the serial line editor
// Receive channel (byte plus line flags) and result channel.
// ----------------------------------------------------------------------------
interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       framing_error;
  logic       overrun;

  modport source (output valid, output rx_byte, output framing_error, output overrun,
                  input ready);
  modport sink   (input valid, input rx_byte, input framing_error, input overrun,
                  output ready);
endinterface

interface sle_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

FILE: src/serial_line_editor.sv
// ----------------------------------------------------------------------------
// serial_line_editor: canonical-mode line editor for a serial receiver
// Line editing with echo, erase, reprint and line delivery.
// ----------------------------------------------------------------------------
// rx carries one received byte with its framing-error and overrun flags per
// word; tx carries result words (kind, out_byte, last), last marking the final
// word caused by one received byte. Both use valid/ready.
// Received words are classified and put in a two-entry command queue in the
// cycle they are taken; ignored control bytes are taken but give no result.
// The sequencer pops a command from the queue, then puts out one result word
// per cycle while tx is ready (ctrl-W first reads the last character in a
// check state). The first result passes through the queue, the sequencer
// state and the output register. A kill-line gives three words (BS, SP, BS)
// for each stored character, up to LINE_BYTES-1 of them, and a ctrl-W on a
// line with no space in it erases the whole line.
// rx stays ready while the queue has room, so up to two words are taken while
// the sequencer works. When tx stalls the output register holds its word and
// the sequencer waits; results are never dropped.
// Reset empties the line and the queue; the line store needs no clearing.
// ----------------------------------------------------------------------------
module serial_line_editor import sle_pkg::*; #(
  parameter int LINE_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst,
  sle_in_if.sink    rx,
  sle_out_if.source tx
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_nempty;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  sle_front u_front (
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_wr_cmd)
  );

  sle_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .nempty (q_nempty)
  );

  sle_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_nempty (q_nempty),
    .q_cmd    (q_rd_cmd),
    .q_pop    (q_pop),
    .tx       (tx)
  );

endmodule

FILE: src/sle_front.sv
// ----------------------------------------------------------------------------
// sle_front: receive side
// Takes received words, classifies them into editor commands and queues them.
// ----------------------------------------------------------------------------
module sle_front import sle_pkg::*; (
  input  logic   rst,
  sle_in_if.sink rx,
  input  logic   q_full,
  output logic   q_push,
  output cmd_t   q_cmd
);

  assign rx.ready = !rst && !q_full;
  assign q_cmd    = classify(rx.rx_byte, rx.framing_error, rx.overrun);
  // ignored control bytes never reach the queue
  assign q_push   = rx.valid && rx.ready && (q_cmd.op != OP_IGNORE);

endmodule

FILE: src/sle_fifo.sv
// ----------------------------------------------------------------------------
// sle_fifo: two-entry command queue
// Decouples the classifier from the edit sequencer.
// ----------------------------------------------------------------------------
module sle_fifo import sle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic nempty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  assign full   = (count == 2'd2);
  assign nempty = (count != 2'd0);
  assign rd_cmd = slots[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nempty)
    else $error("command queue underflow");

endmodule

FILE: src/sle_back.sv
// ----------------------------------------------------------------------------
// sle_back: edit sequencer
// Runs queued commands on the line, one result word a cycle unless tx stalls.
// ----------------------------------------------------------------------------
module sle_back import sle_pkg::*; #(
  parameter int LINE_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nempty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  sle_out_if.source  tx
);

  localparam int             FW       = $clog2(LINE_BYTES);
  localparam logic [FW-1:0]  FILL_MAX = FW'(LINE_BYTES - 1);

  state_t        state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] ptr, ptr_next;
  op_t           op;
  logic [7:0]    ch;

  logic [7:0]    line_mem [LINE_BYTES];
  logic [7:0]    rd_data;
  logic          rd_en;
  logic [FW-1:0] rd_addr;
  logic          wr_en;

  logic          out_valid;
  kind_t         out_kind;
  logic [7:0]    out_byte;
  logic          out_last;

  logic          emit_ok;
  logic          emit;
  kind_t         e_kind;
  logic [7:0]    e_byte;
  logic          e_last;

  kind_t         stat_kind;
  rub_mode_t     mode;
  logic          rub_done;

  assign emit_ok = !out_valid || tx.ready;

  always_comb begin
    case (op)
      OP_EOF:  stat_kind = K_EOF;
      OP_ERR:  stat_kind = K_ERR;
      default: stat_kind = K_INTR;
    endcase
    case (op)
      OP_KILL: mode = RM_KILL;
      OP_WORD: mode = RM_WORD;
      default: mode = RM_SINGLE;
    endcase
    // rd_data holds the character before the one being erased in word mode
    rub_done = (mode == RM_SINGLE) || (fill == FW'(1)) ||
               (mode == RM_WORD && rd_data == CH_SP);
  end

  // outputs
  always_comb begin
    q_pop   = 1'b0;
    emit    = 1'b0;
    e_kind  = K_ECHO;
    e_byte  = '0;
    e_last  = 1'b0;
    rd_en   = 1'b0;
    rd_addr = fill - FW'(1);
    wr_en   = 1'b0;
    case (state)
      S_IDLE: begin
        q_pop = q_nempty;
        if (q_nempty && q_cmd.op == OP_WORD && fill != '0) rd_en = 1'b1;
      end
      S_STAT: begin
        emit   = 1'b1;
        e_kind = stat_kind;
        e_last = 1'b1;
      end
      S_PUT: begin
        emit   = 1'b1;
        e_last = 1'b1;
        if (fill == FILL_MAX) begin
          e_kind = K_BELL;
        end else begin
          e_byte = ch;
          wr_en  = emit_ok;
        end
      end
      S_LCR: begin
        emit   = 1'b1;
        e_byte = CH_CR;
      end
      S_LLF: begin
        emit    = 1'b1;
        e_byte  = CH_LF;
        rd_en   = emit_ok;
        rd_addr = '0;
      end
      S_LBODY: begin
        emit   = 1'b1;
        e_kind = K_LINE;
        e_byte = rd_data;
        if (ptr != fill - FW'(1)) begin
          rd_en   = emit_ok;
          rd_addr = ptr + 1'b1;
        end
      end
      S_LEND: begin
        emit   = 1'b1;
        e_kind = K_LINE;
        e_byte = CH_LF;
        e_last = 1'b1;
      end
      S_RCR: begin
        emit    = 1'b1;
        e_byte  = CH_CR;
        e_last  = (fill == '0);
        rd_en   = emit_ok;
        rd_addr = '0;
      end
      S_RBODY: begin
        emit   = 1'b1;
        e_byte = rd_data;
        e_last = (ptr == fill - FW'(1));
        if (ptr != fill - FW'(1)) begin
          rd_en   = emit_ok;
          rd_addr = ptr + 1'b1;
        end
      end
      S_WCHK: begin
      end
      S_RUB1: begin
        emit   = 1'b1;
        e_byte = CH_BS;
        if (mode == RM_WORD && fill != FW'(1)) begin
          rd_en   = emit_ok;
          rd_addr = fill - FW'(2);
        end
      end
      S_RUB2: begin
        emit   = 1'b1;
        e_byte = CH_SP;
      end
      S_RUB3: begin
        emit   = 1'b1;
        e_byte = CH_BS;
        e_last = rub_done;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    fill_next  = fill;
    ptr_next   = ptr;
    case (state)
      S_IDLE: begin
        if (q_nempty) begin
          case (q_cmd.op)
            OP_EOF, OP_ERR, OP_INTR: state_next = S_STAT;
            OP_LINE:                 state_next = S_LCR;
            OP_PUT:                  state_next = S_PUT;
            OP_BS, OP_KILL:          state_next = (fill != '0) ? S_RUB1 : S_IDLE;
            OP_WORD:                 state_next = (fill != '0) ? S_WCHK : S_IDLE;
            OP_REPRINT:              state_next = S_RCR;
            default:                 state_next = S_IDLE;
          endcase
        end
      end
      S_STAT: begin
        if (emit_ok) begin
          state_next = S_IDLE;
          fill_next  = '0;
        end
      end
      S_PUT: begin
        if (emit_ok) begin
          state_next = S_IDLE;
          if (fill != FILL_MAX) fill_next = fill + 1'b1;
        end
      end
      S_LCR: begin
        if (emit_ok) state_next = S_LLF;
      end
      S_LLF: begin
        if (emit_ok) begin
          ptr_next   = '0;
          state_next = (fill == '0) ? S_LEND : S_LBODY;
        end
      end
      S_LBODY: begin
        if (emit_ok) begin
          if (ptr == fill - FW'(1)) state_next = S_LEND;
          else                      ptr_next   = ptr + 1'b1;
        end
      end
      S_LEND: begin
        if (emit_ok) begin
          state_next = S_IDLE;
          fill_next  = '0;
        end
      end
      S_RCR: begin
        if (emit_ok) begin
          ptr_next   = '0;
          state_next = (fill == '0) ? S_IDLE : S_RBODY;
        end
      end
      S_RBODY: begin
        if (emit_ok) begin
          if (ptr == fill - FW'(1)) state_next = S_IDLE;
          else                      ptr_next   = ptr + 1'b1;
        end
      end
      S_WCHK: begin
        state_next = (rd_data == CH_SP) ? S_IDLE : S_RUB1;
      end
      S_RUB1: begin
        if (emit_ok) state_next = S_RUB2;
      end
      S_RUB2: begin
        if (emit_ok) state_next = S_RUB3;
      end
      S_RUB3: begin
        if (emit_ok) begin
          fill_next  = fill - FW'(1);
          state_next = rub_done ? S_IDLE : S_RUB1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      ptr   <= '0;
      op    <= OP_IGNORE;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      ptr   <= ptr_next;
      if (q_pop) op <= q_cmd.op;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) ch <= q_cmd.ch;
  end

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[fill] <= ch;
    if (rd_en) rd_data <= line_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && emit_ok) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && emit_ok) begin
      out_kind <= e_kind;
      out_byte <= e_byte;
      out_last <= e_last;
    end
  end

  assign tx.valid    = out_valid;
  assign tx.kind     = out_kind;
  assign tx.out_byte = out_byte;
  assign tx.last     = out_last;

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_LEND && emit_ok) |=> fill == '0)
    else $error("line delivery did not clear the line");
  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && emit_ok && fill != FILL_MAX) |=> fill == $past(fill) + 1'b1)
    else $error("stored character not counted");
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != K_ECHO && out_kind != K_LINE) |-> out_byte == '0)
    else $error("status word carries a byte");

endmodule

FILE: sim/tb_serial_line_editor.sv
// ----------------------------------------------------------------------------
// tb_serial_line_editor: self-checking bench for the serial line editor
// Drives received bytes with flags through the rx channel under random bursts
// and gaps, predicts every echo, line, bell and status word from a local
// line-store model, and checks each tx word in order while tx stalls.
// ----------------------------------------------------------------------------
module tb_serial_line_editor;
  import sle_pkg::*;

  localparam int LINE_BYTES  = 16;
  localparam int END_CYCLES  = 3 * (LINE_BYTES - 1) * 2 + 40;
  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 380;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst;

  sle_in_if  rx_if ();
  sle_out_if tx_if ();

  serial_line_editor #(.LINE_BYTES(LINE_BYTES)) u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // line editor model
  logic [7:0]   line_model [LINE_BYTES];
  int           fill_model = 0;
  result_word_t staged_words [$];
  result_word_t expected_words [$];

  int mismatches   = 0;
  int useful_items = 0;
  int burst_left   = 0;
  int hold_left    = 0;

  function automatic void stage(kind_t k, logic [7:0] d);
    result_word_t w;
    w.kind = k;
    w.data = d;
    w.last = 1'b0;
    staged_words.push_back(w);
  endfunction

  function automatic void rub_char();
    stage(K_ECHO, CH_BS);
    stage(K_ECHO, CH_SP);
    stage(K_ECHO, CH_BS);
    fill_model--;
  endfunction

  function automatic void predict_edit(logic [7:0] b, logic fe, logic ovr);
    logic [7:0] c;
    staged_words = {};
    c = (b == CH_CR) ? CH_LF : b;
    if (fe) begin
      stage(K_EOF, 8'h00);
      fill_model = 0;
    end else if (ovr) begin
      stage(K_ERR, 8'h00);
      fill_model = 0;
    end else if (c == CH_LF) begin
      line_model[fill_model] = CH_LF;
      stage(K_ECHO, CH_CR);
      stage(K_ECHO, CH_LF);
      for (int i = 0; i < fill_model; i++) stage(K_LINE, line_model[i]);
      stage(K_LINE, CH_LF);
      fill_model = 0;
    end else begin
      if (c == CH_TAB) c = CH_SP;
      if ((c >= CH_SP && c <= CH_TOP) || c >= CH_HIGH) begin
        if (fill_model >= LINE_BYTES - 1) begin
          stage(K_BELL, 8'h00);
        end else begin
          line_model[fill_model] = c;
          fill_model++;
          stage(K_ECHO, c);
        end
      end else begin
        case (c)
          CTL_C: begin
            stage(K_INTR, 8'h00);
            fill_model = 0;
          end
          CH_BS, CH_DEL: begin
            if (fill_model > 0) rub_char();
          end
          CTL_R: begin
            stage(K_ECHO, CH_CR);
            for (int i = 0; i < fill_model; i++) stage(K_ECHO, line_model[i]);
          end
          CTL_U: begin
            while (fill_model > 0) rub_char();
          end
          CTL_W: begin
            while (fill_model > 0 && line_model[fill_model - 1] != CH_SP) rub_char();
          end
          default: ;
        endcase
      end
    end
    if (staged_words.size() > 0) begin
      staged_words[staged_words.size() - 1].last = 1'b1;
      useful_items++;
    end
    foreach (staged_words[i]) expected_words.push_back(staged_words[i]);
  endfunction

  // sender: bursts of words with random gaps
  task automatic send_word(input logic [7:0] b, input logic fe = 1'b0,
                           input logic ovr = 1'b0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    burst_left--;
    rx_if.valid         <= 1'b1;
    rx_if.rx_byte       <= b;
    rx_if.framing_error <= fe;
    rx_if.overrun       <= ovr;
    do @(posedge clk); while (!rx_if.ready);
    predict_edit(b, fe, ovr);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: stall pattern re-picked among four modes, plus forced hold-off
  int rx_mode  = 0;
  int rx_phase = 0;

  always @(negedge clk) begin
    rx_phase++;
    if (rx_phase % 50 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      tx_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       tx_if.ready <= 1'b1;
        1:       tx_if.ready <= ($urandom_range(0, 3) != 0);
        2:       tx_if.ready <= ((rx_phase % 7) < 2);
        default: tx_if.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    result_word_t w;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d byte=%02h last=%0b", $time,
                 tx_if.kind, tx_if.out_byte, tx_if.last);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        if (tx_if.kind !== w.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, w.kind, tx_if.kind);
          mismatches++;
        end
        if (tx_if.out_byte !== w.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, w.data,
                   tx_if.out_byte);
          mismatches++;
        end
        if (tx_if.last !== w.last) begin
          $display("%0t: last expected %0b actual %0b", $time, w.last, tx_if.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
    $display("tb_serial_line_editor: errors");
    $finish;
  end

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0:       return CH_TAB;
      1:       return CH_SP;
      2:       return 8'($urandom_range(8'hA0, 8'hFF));
      default: return 8'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] pick_edit_byte();
    case ($urandom_range(0, 4))
      0:       return CH_BS;
      1:       return CH_DEL;
      2:       return CTL_W;
      3:       return CTL_R;
      default: return CTL_U;
    endcase
  endfunction

  task automatic test_edit_keys();
    send_word(8'h41);
    send_word(CH_SP);
    send_word(CH_TOP);
    send_word(CH_HIGH);
    send_word(8'hFF);
    send_word(CH_TAB);
    send_word(CH_DEL);
    send_word(CH_BS);
    send_word(CTL_R);
    send_word(8'h00);
    send_word(8'h1F);
    send_word(8'h80);
    send_word(8'h9F);
    send_word(CTL_W);
    send_word(CTL_U);
    send_word(CTL_U);
    send_word(CH_BS);
    send_word(8'h78);
    send_word(CH_CR);
    send_word(CH_LF);
    send_word(8'h79);
    send_word(CTL_C);
    send_word(8'h55, 1'b1, 1'b1);
    send_word(8'hAA, 1'b0, 1'b1);
    send_word(8'h7A);
    send_word(8'h00, 1'b1, 1'b0);
    wait_drained();
  endtask

  // tx held off while a full line, bell, reprint and kill-line are offered
  task automatic test_stalled_output();
    hold_left = 300;
    for (int i = 0; i < LINE_BYTES; i++) send_word(pick_text_byte());
    send_word(CTL_R);
    send_word(CTL_U);
    for (int i = 0; i < 5; i++) send_word(pick_text_byte());
    send_word(CH_CR);
    wait_drained();
  endtask

  task automatic test_random_lines();
    int len;
    int ending;
    while (useful_items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom), ($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0));
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 15) send_word(pick_edit_byte());
          else send_word(pick_text_byte());
        end
        ending = $urandom_range(0, 19);
        if (ending < 8) send_word(CH_CR);
        else if (ending < 16) send_word(CH_LF);
        else if (ending == 16) send_word(CTL_C);
        else if (ending == 17) send_word(8'($urandom), 1'b1, 1'($urandom));
        else if (ending == 18) send_word(8'($urandom), 1'b0, 1'b1);
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    rx_if.valid         = 1'b0;
    rx_if.rx_byte       = 8'h00;
    rx_if.framing_error = 1'b0;
    rx_if.overrun       = 1'b0;
    tx_if.ready         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edit_keys();
    test_stalled_output();
    test_random_lines();
    wait_drained();

    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_serial_line_editor: clean");
    end else begin
      $display("tb_serial_line_editor: errors");
    end
    $finish;
  end

endmodule
